>>> src/pwet_pkg.sv
// ----------------------------------------------------------------------------
// pwet_pkg
// Shared types, constants and helpers of the packed-word edge timestamper.
// ----------------------------------------------------------------------------
`default_nettype none

package pwet_pkg;

  // samples per packed word and bits to address one of them
  localparam int WORD_SAMPLES = 64;
  localparam int BIT_W        = $clog2(WORD_SAMPLES);

  // absolute sample index and word counter
  localparam int INDEX_BITS = 48;
  localparam int COUNTER_W  = INDEX_BITS - BIT_W;
  localparam logic [COUNTER_W-1:0] COUNTER_MAX = {COUNTER_W{1'b1}};

  // channel tag and configuration port
  localparam int TAG_W     = 6;
  localparam int CFG_W     = INDEX_BITS;
  localparam int CFG_IDX_W = 1;

  // shortest capture that can hold an edge
  localparam logic [INDEX_BITS-1:0] MIN_SAMPLES = INDEX_BITS'(2);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPTURE_LEN       = 1'b0,
    REG_REFERENCE_CHANNEL = 1'b1
  } cfg_reg_t;

  // one scanned word waiting for the emitter
  typedef struct packed {
    logic [WORD_SAMPLES-1:0] mask;     // edges still to emit
    logic [WORD_SAMPLES-1:0] word;     // samples, gives direction
    logic [COUNTER_W-1:0]    counter;  // word number, upper index bits
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // isolate the lowest set bit
  function automatic logic [WORD_SAMPLES-1:0] lowest_one(input logic [WORD_SAMPLES-1:0] m);
    lowest_one = m & (~m + WORD_SAMPLES'(1));
  endfunction

  // encode a one-hot vector into a bit position
  function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_SAMPLES-1:0] oh);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < WORD_SAMPLES; k++) begin
      if (oh[k]) begin
        idx = idx | BIT_W'(k);
      end
    end
    onehot_index = idx;
  endfunction

endpackage

`default_nettype wire

>>> src/pwet_front.sv
// ----------------------------------------------------------------------------
// pwet_front
// Holds configuration and scan state, accepts words, builds the edge mask.
// ----------------------------------------------------------------------------
`default_nettype none

module pwet_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pwet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pwet_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              word_valid,
  output logic                                   word_stall,
  input  wire logic [pwet_pkg::WORD_SAMPLES-1:0] sample_word,
  input  wire logic [pwet_pkg::TAG_W-1:0]        channel_tag,
  input  wire logic                              first_word,
  input  wire pwet_pkg::q_status_t               q_status,
  output logic                                   push,
  output pwet_pkg::entry_t                       push_entry
);

  logic [pwet_pkg::INDEX_BITS-1:0]   sample_total;
  logic [pwet_pkg::TAG_W-1:0]        reference_channel;
  logic                              prev_bit;
  logic [pwet_pkg::COUNTER_W-1:0]    word_counter;

  logic                              accept;
  logic                              scan;
  logic [pwet_pkg::COUNTER_W-1:0]    cnt;
  logic [pwet_pkg::WORD_SAMPLES-1:0] changed;
  logic [pwet_pkg::WORD_SAMPLES-1:0] limit;
  logic [pwet_pkg::WORD_SAMPLES-1:0] edges;
  logic [pwet_pkg::COUNTER_W-1:0]    sc_word;
  logic [pwet_pkg::BIT_W-1:0]        sc_bit;

  // stall only while the queue cannot take another word
  assign word_stall = q_status.full;
  assign accept     = word_valid && !q_status.full;
  assign scan       = accept && (channel_tag == reference_channel);

  // a new capture restarts the word count
  assign cnt = first_word ? '0 : word_counter;

  // compare each sample with the one before it
  always_comb begin
    changed    = sample_word ^ {sample_word[pwet_pkg::WORD_SAMPLES-2:0], prev_bit};
    changed[0] = changed[0] && !first_word;
  end

  // keep only samples below the configured capture length
  assign sc_word = sample_total[pwet_pkg::INDEX_BITS-1:pwet_pkg::BIT_W];
  assign sc_bit  = sample_total[pwet_pkg::BIT_W-1:0];

  always_comb begin
    if (sample_total < pwet_pkg::MIN_SAMPLES) begin
      limit = '0;
    end else if (cnt < sc_word) begin
      limit = '1;
    end else if (cnt == sc_word) begin
      limit = (pwet_pkg::WORD_SAMPLES'(1) << sc_bit) - pwet_pkg::WORD_SAMPLES'(1);
    end else begin
      limit = '0;
    end
  end

  assign edges = changed & limit;

  // queue only words that have something to emit
  assign push               = scan && (edges != '0);
  assign push_entry.mask    = edges;
  assign push_entry.word    = sample_word;
  assign push_entry.counter = cnt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total      <= '0;
      reference_channel <= '0;
    end else if (cfg_we) begin
      case (pwet_pkg::cfg_reg_t'(cfg_index))
        pwet_pkg::REG_CAPTURE_LEN:       sample_total      <= cfg_data;
        pwet_pkg::REG_REFERENCE_CHANNEL: reference_channel <= cfg_data[pwet_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // advance scan state on every word of the reference channel
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_bit     <= 1'b0;
      word_counter <= '0;
    end else if (scan) begin
      prev_bit     <= sample_word[pwet_pkg::WORD_SAMPLES-1];
      word_counter <= (cnt == pwet_pkg::COUNTER_MAX) ? cnt
                                                      : cnt + pwet_pkg::COUNTER_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> src/pwet_queue.sv
// ----------------------------------------------------------------------------
// pwet_queue
// Two-entry queue of scanned words between the front and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module pwet_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pwet_pkg::entry_t push_entry,
  input  wire logic             pop,
  output pwet_pkg::entry_t      head,
  output pwet_pkg::q_status_t   q_status
);

  pwet_pkg::entry_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);

  // hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/pwet_back.sv
// ----------------------------------------------------------------------------
// pwet_back
// Emits one edge beat per cycle while edge_stall is low, from the current word, lowest sample first.
// ----------------------------------------------------------------------------
`default_nettype none

module pwet_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pwet_pkg::q_status_t             q_status,
  input  wire pwet_pkg::entry_t                head,
  output logic                                 pop,
  output logic                                 edge_valid,
  input  wire logic                            edge_stall,
  output logic [pwet_pkg::INDEX_BITS-1:0]      edge_index,
  output logic                                 rising,
  output logic                                 last_of_word
);

  logic                              busy;
  logic [pwet_pkg::WORD_SAMPLES-1:0] cur_mask;
  logic [pwet_pkg::WORD_SAMPLES-1:0] cur_word;
  logic [pwet_pkg::COUNTER_W-1:0]    cur_counter;

  logic [pwet_pkg::WORD_SAMPLES-1:0] lsb;
  logic [pwet_pkg::WORD_SAMPLES-1:0] rest;
  logic [pwet_pkg::BIT_W-1:0]        step_bit;
  logic                              step_last;
  logic                              step_rising;
  logic                              step;

  // load a word when idle
  assign pop = !busy && !q_status.empty;

  // pick the lowest pending edge
  assign lsb         = pwet_pkg::lowest_one(cur_mask);
  assign step_bit    = pwet_pkg::onehot_index(lsb);
  assign rest        = cur_mask & ~lsb;
  assign step_last   = (rest == '0);
  assign step_rising = |(cur_word & lsb);

  // emit when the output register is free or drains this cycle
  assign step = busy && (!edge_valid || !edge_stall);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      edge_valid <= 1'b0;
    end else begin
      if (step) begin
        edge_valid <= 1'b1;
      end else if (!edge_stall) begin
        edge_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (step && step_last) begin
        busy <= 1'b0;
      end
    end
  end

  // payload of the current word and the output beat
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mask    <= head.mask;
      cur_word    <= head.word;
      cur_counter <= head.counter;
    end else if (step) begin
      cur_mask <= rest;
    end
    if (step) begin
      edge_index   <= {cur_counter, step_bit};
      rising       <= step_rising;
      last_of_word <= step_last;
    end
  end

`ifndef SYNTHESIS
  a_busy_has_edge: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur_mask != '0))
    else $error("emitter busy with no pending edge");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (step && step_last) |=> !busy)
    else $error("emitter still busy after last edge of word");

  a_step_shows: assert property (@(posedge clk) disable iff (rst)
    step |=> (edge_valid && (edge_index[pwet_pkg::BIT_W-1:0] == $past(step_bit))))
    else $error("emitted edge not presented on output");
`endif

endmodule

`default_nettype wire

>>> src/packed_word_edge_timestamper_core.sv
// A word with edges is queued, then loaded into the emitter; its edges go out one per
// cycle while edge_stall is low; the next word loads only after its last edge.
// A word with no edge to emit is never queued and does not hold the emitter.
// A two-entry queue lets the front take words while the emitter is busy.
// Reset (rst, synchronous): clears configuration, scan state, queue and output valid.
// ----------------------------------------------------------------------------
// packed_word_edge_timestamper_core
// Top level: front scanner, word queue and edge emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_word_edge_timestamper_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pwet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pwet_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              word_valid,
  output logic                                   word_stall,
  input  wire logic [pwet_pkg::WORD_SAMPLES-1:0] sample_word,
  input  wire logic [pwet_pkg::TAG_W-1:0]        channel_tag,
  input  wire logic                              first_word,
  output logic                                   edge_valid,
  input  wire logic                              edge_stall,
  output logic [pwet_pkg::INDEX_BITS-1:0]        edge_index,
  output logic                                   rising,
  output logic                                   last_of_word
);

  pwet_pkg::q_status_t q_status;
  pwet_pkg::entry_t    push_entry;
  pwet_pkg::entry_t    head;
  logic                push;
  logic                pop;

  // scan and classify words
  pwet_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .sample_word (sample_word),
    .channel_tag (channel_tag),
    .first_word  (first_word),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  // buffer words with edges
  pwet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // emit edge beats
  pwet_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .edge_index   (edge_index),
    .rising       (rising),
    .last_of_word (last_of_word)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed-word edge timestamper. A scoreboard
// class predicts the edge beats of every accepted word (index, direction,
// last-of-word mark) from its own copy of the configuration and scan state,
// and matches them in order against the edge beats seen on the output.
// Stimulus: a directed opening, then capture-like word sequences with sparse
// edges, mixed with other-channel words and noise, under random stalls.
// ----------------------------------------------------------------------------

module tb_top;

  // one predicted edge beat
  typedef struct packed {
    logic [pwet_pkg::INDEX_BITS-1:0] index;
    logic                            rising;
    logic                            last_mark;
  } edge_beat_t;

  // Prediction and matching of edge beats
  class timestamp_board;
    logic [pwet_pkg::INDEX_BITS-1:0] sample_limit;
    logic [pwet_pkg::TAG_W-1:0]      scan_channel;
    logic                            carry_bit;
    logic [pwet_pkg::COUNTER_W-1:0]  word_number;
    edge_beat_t                      pending_edges[$];
    int                              errors;

    function new();
      sample_limit = '0;
      scan_channel = '0;
      carry_bit    = 1'b0;
      word_number  = '0;
      errors       = 0;
    endfunction

    function void set_reg(pwet_pkg::cfg_reg_t r, logic [pwet_pkg::CFG_W-1:0] v);
      if (r == pwet_pkg::REG_CAPTURE_LEN) begin
        sample_limit = v[pwet_pkg::INDEX_BITS-1:0];
      end else begin
        scan_channel = v[pwet_pkg::TAG_W-1:0];
      end
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    // Scan one accepted word and queue the edge beats it must produce
    function void take_word(logic [pwet_pkg::WORD_SAMPLES-1:0] w,
                            logic [pwet_pkg::TAG_W-1:0] tag, logic first);
      logic [pwet_pkg::WORD_SAMPLES-1:0] changed;
      logic [pwet_pkg::INDEX_BITS-1:0]   base;
      logic [pwet_pkg::INDEX_BITS-1:0]   idx;
      edge_beat_t                        held;
      bit                                have_held;
      have_held = 0;
      held      = '0;
      if (tag != scan_channel) return;
      if (first) word_number = '0;
      changed = w ^ {w[pwet_pkg::WORD_SAMPLES-2:0], carry_bit};
      if (first) changed[0] = 1'b0;
      base = {word_number, {pwet_pkg::BIT_W{1'b0}}};
      if (sample_limit >= pwet_pkg::MIN_SAMPLES) begin
        for (int b = 0; b < pwet_pkg::WORD_SAMPLES; b++) begin
          idx = base + pwet_pkg::INDEX_BITS'(b);
          if (changed[b] && idx < sample_limit) begin
            // hold back one beat so the final one can carry the mark
            if (have_held) pending_edges.insert(pending_edges.size(), held);
            held      = '{index: idx, rising: w[b], last_mark: 1'b0};
            have_held = 1;
          end
        end
        if (have_held) begin
          held.last_mark = 1'b1;
          pending_edges.insert(pending_edges.size(), held);
        end
      end
      carry_bit = w[pwet_pkg::WORD_SAMPLES-1];
      if (word_number != pwet_pkg::COUNTER_MAX)
        word_number = word_number + pwet_pkg::COUNTER_W'(1);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Compare one accepted edge beat against the oldest prediction
    task match_edge(logic [pwet_pkg::INDEX_BITS-1:0] idx, logic r, logic l);
      edge_beat_t e;
      if (pending_edges.size() == 0) begin
        report($sformatf("unexpected edge beat index %0d rising %0b", idx, r));
        return;
      end
      e = pending_edges.pop_front();
      if (idx !== e.index) report($sformatf("edge_index %0d, want %0d", idx, e.index));
      if (r !== e.rising)
        report($sformatf("rising %0b at index %0d, want %0b", r, e.index, e.rising));
      if (l !== e.last_mark)
        report($sformatf("last_of_word %0b at index %0d, want %0b", l, e.index, e.last_mark));
    endtask

    task flush_check();
      if (pending_edges.size() != 0)
        report($sformatf("%0d edge beats never arrived", pending_edges.size()));
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_we;
  logic [pwet_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [pwet_pkg::CFG_W-1:0]        cfg_data;
  logic                              word_valid;
  logic                              word_stall;
  logic [pwet_pkg::WORD_SAMPLES-1:0] sample_word;
  logic [pwet_pkg::TAG_W-1:0]        channel_tag;
  logic                              first_word;
  logic                              edge_valid;
  logic                              edge_stall;
  logic [pwet_pkg::INDEX_BITS-1:0]   edge_index;
  logic                              rising;
  logic                              last_of_word;

  timestamp_board board;
  int send_idle_pct;
  int recv_idle_pct;

  packed_word_edge_timestamper_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .sample_word  (sample_word),
    .channel_tag  (channel_tag),
    .first_word   (first_word),
    .edge_valid   (edge_valid),
    .edge_stall   (edge_stall),
    .edge_index   (edge_index),
    .rising       (rising),
    .last_of_word (last_of_word)
  );

  always #4 clk = ~clk;

  // Stall the edge side at random
  always @(negedge clk) begin
    edge_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted edge beat
  always @(posedge clk) begin
    if (!rst && edge_valid && !edge_stall) begin
      board.match_edge(edge_index, rising, last_of_word);
    end
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic write_reg(input pwet_pkg::cfg_reg_t r, input logic [pwet_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(r, v);
  endtask

  // Send one word beat, idling first at random, and note it once accepted
  task automatic drive_word(input logic [pwet_pkg::WORD_SAMPLES-1:0] w,
                            input logic [pwet_pkg::TAG_W-1:0] tag, input logic first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word_valid  <= 1'b1;
    sample_word <= w;
    channel_tag <= tag;
    first_word  <= first;
    do @(posedge clk); while (word_stall);
    board.take_word(w, tag, first);
  endtask

  // Hold the sender until every predicted beat has come, then let the pipe drain
  task automatic settle();
    @(negedge clk);
    word_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // A word at a steady level with a few transitions at random places
  function automatic logic [pwet_pkg::WORD_SAMPLES-1:0] sync_word(input logic level,
                                                                  input int toggles);
    logic [pwet_pkg::WORD_SAMPLES-1:0] w;
    int                                pos;
    w = {pwet_pkg::WORD_SAMPLES{level}};
    for (int t = 0; t < toggles; t++) begin
      pos = $urandom_range(pwet_pkg::WORD_SAMPLES - 1);
      w   = w ^ ({pwet_pkg::WORD_SAMPLES{1'b1}} << pos);
    end
    return w;
  endfunction

  function automatic logic [pwet_pkg::WORD_SAMPLES-1:0] noise_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [pwet_pkg::TAG_W-1:0] other_tag(input logic [pwet_pkg::TAG_W-1:0] chan);
    return chan + pwet_pkg::TAG_W'($urandom_range(1, 62));
  endfunction

  task automatic random_config();
    logic [63:0]                wide;
    logic [pwet_pkg::CFG_W-1:0] count;
    wide = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       count = '0;
      1:       count = pwet_pkg::CFG_W'(1);
      2:       count = pwet_pkg::MIN_SAMPLES;
      3:       count = {pwet_pkg::CFG_W{1'b1}};
      4:       count = wide[pwet_pkg::CFG_W-1:0];
      default: count = pwet_pkg::CFG_W'($urandom_range(3, 900));
    endcase
    settle();
    write_reg(pwet_pkg::REG_CAPTURE_LEN, count);
    // upper data bits are don't-care for the channel register
    write_reg(pwet_pkg::REG_REFERENCE_CHANNEL,
              {wide[pwet_pkg::CFG_W-1:pwet_pkg::TAG_W], pwet_pkg::TAG_W'($urandom_range(63))});
  endtask

  // One capture on the scanned channel, with foreign words slipped in
  task automatic capture(output int n);
    logic                              level;
    logic [pwet_pkg::WORD_SAMPLES-1:0] w;
    int                                words;
    n     = 0;
    words = $urandom_range(1, 14);
    level = 1'($urandom_range(1));
    for (int k = 0; k < words; k++) begin
      if ($urandom_range(99) < 20) begin
        drive_word(noise_word(), other_tag(board.scan_channel), 1'($urandom_range(1)));
        n++;
      end
      case ($urandom_range(9))
        0:       w = noise_word();
        1, 2:    w = {pwet_pkg::WORD_SAMPLES{level}};
        default: w = sync_word(level, $urandom_range(1, 3));
      endcase
      drive_word(w, board.scan_channel, (k == 0) || ($urandom_range(99) < 4));
      level = w[pwet_pkg::WORD_SAMPLES-1];
      n++;
    end
  endtask

  // Unstructured words: random content, flags and tags
  task automatic noise_burst(output int n);
    logic [pwet_pkg::TAG_W-1:0] tag;
    n = 0;
    repeat ($urandom_range(1, 6)) begin
      tag = ($urandom_range(99) < 70) ? board.scan_channel
                                      : pwet_pkg::TAG_W'($urandom_range(63));
      drive_word(noise_word(), tag, 1'($urandom_range(1)));
      n++;
    end
  endtask

  task automatic random_phase(input int target);
    int done;
    int n;
    done = 0;
    random_config();
    while (done < target) begin
      if ($urandom_range(99) < 30) random_config();
      if ($urandom_range(99) < 15) noise_burst(n);
      else capture(n);
      done += n;
    end
  endtask

  task automatic directed();
    // no first word after reset: bit 0 compares against a zero carry
    write_reg(pwet_pkg::REG_CAPTURE_LEN, {pwet_pkg::CFG_W{1'b1}});
    write_reg(pwet_pkg::REG_REFERENCE_CHANNEL, '0);
    drive_word(64'h0000_0000_0000_0001, 6'd0, 1'b0);
    drive_word({pwet_pkg::WORD_SAMPLES{1'b1}}, 6'd0, 1'b0);
    drive_word('0, 6'd0, 1'b0);
    // new capture: bit 0 never an edge, then words full of edges
    drive_word(64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b1);
    drive_word(64'h5555_5555_5555_5555, 6'd0, 1'b0);
    drive_word(64'h5555_5555_5555_5555, 6'd0, 1'b0);
    // other channel, even with the first flag set: ignored
    drive_word({pwet_pkg::WORD_SAMPLES{1'b1}}, 6'd63, 1'b1);
    drive_word(64'h8000_0000_0000_0000, 6'd0, 1'b0);
    settle();

    // scan the top channel; channel 0 is now foreign
    write_reg(pwet_pkg::REG_REFERENCE_CHANNEL, pwet_pkg::CFG_W'(63));
    drive_word(noise_word(), 6'd0, 1'b1);
    drive_word(64'hFFFF_0000_FFFF_0000, 6'd63, 1'b1);
    drive_word(64'h0F0F_0000_0000_F0F1, 6'd63, 1'b0);
    settle();

    // short captures: nothing emitted, state still advances
    write_reg(pwet_pkg::REG_CAPTURE_LEN, '0);
    drive_word(64'h0000_0000_0000_0FF0, 6'd63, 1'b1);
    drive_word(64'hFFFF_FFFF_0000_0000, 6'd63, 1'b0);
    settle();
    write_reg(pwet_pkg::REG_CAPTURE_LEN, pwet_pkg::CFG_W'(1));
    drive_word(64'h0000_0000_0000_0003, 6'd63, 1'b0);
    settle();

    // edges at or past the capture length are dropped
    write_reg(pwet_pkg::REG_CAPTURE_LEN, pwet_pkg::MIN_SAMPLES);
    drive_word(64'h0000_0000_0000_0006, 6'd63, 1'b1);
    drive_word(64'h0000_0000_0000_0001, 6'd63, 1'b0);
    settle();
    write_reg(pwet_pkg::REG_CAPTURE_LEN, pwet_pkg::CFG_W'(100));
    drive_word('0, 6'd63, 1'b1);
    drive_word(64'h00FF_0000_FFFF_0000, 6'd63, 1'b0);
    drive_word(64'h0000_0000_0000_0001, 6'd63, 1'b0);
    settle();
  endtask

  initial begin
    board         = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = pwet_pkg::REG_CAPTURE_LEN;
    cfg_data      = '0;
    word_valid    = 1'b0;
    sample_word   = '0;
    channel_tag   = '0;
    first_word    = 1'b0;
    edge_stall    = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 80;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed();

    // sender slow, receiver slower; then swapped; then flat out
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 80 : 0;
      recv_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 16 : 0;
      random_phase(140);
    end

    settle();
    repeat (16) @(posedge clk);
    board.flush_check();
    if (board.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> packed_word_edge_timestamper_core.f
src/pwet_pkg.sv
src/pwet_front.sv
src/pwet_queue.sv
src/pwet_back.sv
src/packed_word_edge_timestamper_core.sv
tb/sv/tb_top.sv
